// ===== src/ipsc_pkg.sv =====
// Package for the IPv4 payload XOR scrambler: beat structs, item kinds
// and the fixed constants of header parsing and key rotation. No dependencies.
package ipsc_pkg;

    // Item kinds carried in the func field.
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_KEY  = 2'd2;

    // Key handling.
    localparam logic [7:0]  KEY_RESET      = 8'h5A;
    localparam logic [7:0]  KEY_STEP       = 8'd17;
    localparam logic [15:0] INTERVAL_RESET = 16'd10;

    // Header parsing.
    localparam logic [15:0] POS_MAX       = 16'hFFFF;
    localparam logic [15:0] POS_VER_IHL   = 16'd0;
    localparam logic [15:0] POS_LEN_HI    = 16'd2;
    localparam logic [15:0] POS_LEN_LO    = 16'd3;
    localparam logic [15:0] POS_PROTO     = 16'd9;
    localparam logic [15:0] TCP_DOFF_OFS  = 16'd12;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [6:0]  UDP_HDR_BYTES = 7'd8;
    localparam logic [3:0]  MIN_DOFF      = 4'd5;

    // One input beat.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       was_changed;
        logic       truncated;
    } result_t;

    // Handshake between the input register and the processing stage.
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

// ===== src/ipsc_in_reg.sv =====
// Input register of the scrambler: holds one accepted beat for the processing stage.
// Depends on ipsc_pkg.
module ipsc_in_reg
    import ipsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  item_t  item,
    output stage_t stage,
    input  logic   take
);

    logic  valid_reg;
    logic  valid_next;
    item_t data_reg;

    // A new beat may enter when the register is empty or is being drained.
    assign item_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
        begin
            valid_next = item_valid;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Beat payload.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            data_reg <= item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = data_reg;

endmodule

// ===== src/ipsc_core.sv =====
// Processing stage of the scrambler: header parser, key and tick state, and
// the result register. Depends on ipsc_pkg.
module ipsc_core
    import ipsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_t      stage,
    output logic        take,
    input  logic [15:0] rotate_interval,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    logic [15:0] pos_reg, pos_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [6:0]  pstart_reg, pstart_next;
    logic        armed_reg, armed_next;
    logic [7:0]  pkey_reg, pkey_next;
    logic [7:0]  ckey_reg, ckey_next;
    logic [15:0] tick_reg, tick_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic        is_byte;
    logic [7:0]  b;
    logic [15:0] tick_inc;
    logic        hdr_ok;
    logic [15:0] tcp_doff_pos;
    logic [3:0]  doff;
    logic [6:0]  pstart_udp;
    logic [6:0]  pstart_tcp;
    logic        change;
    logic        trunc;

    assign is_byte = (stage.item.func == FUNC_BYTE);
    assign b       = stage.item.data_byte;

    // Packet bytes need room in the result register; other kinds never stall.
    assign take = stage.valid && (!is_byte || !res_valid_reg || result_ready);

    assign tick_inc     = tick_reg + 16'd1;
    assign hdr_ok       = (ihb_reg >= MIN_HDR_BYTES);
    assign tcp_doff_pos = {10'd0, ihb_reg} + TCP_DOFF_OFS;
    assign doff         = b[7:4];
    assign pstart_udp   = {1'b0, ihb_reg} + UDP_HDR_BYTES;
    assign pstart_tcp   = {1'b0, ihb_reg} + {1'b0, doff, 2'b00};

    // Next state for the beat in the stage.
    always_comb
    begin
        pos_next       = pos_reg;
        ihb_next       = ihb_reg;
        proto_next     = proto_reg;
        tlen_next      = tlen_reg;
        pstart_next    = pstart_reg;
        armed_next     = armed_reg;
        pkey_next      = pkey_reg;
        ckey_next      = ckey_reg;
        tick_next      = tick_reg;
        res_next       = res_reg;
        change         = 1'b0;
        trunc          = 1'b0;
        res_valid_next = res_valid_reg && !result_ready;

        if (take)
        begin
            case (stage.item.func)
                FUNC_TICK:
                begin
                    // Rotate the key once the interval count is reached.
                    if (tick_inc >= rotate_interval)
                    begin
                        ckey_next = ckey_reg + KEY_STEP;
                        tick_next = 16'd0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                FUNC_KEY:
                begin
                    ckey_next = b;
                end
                FUNC_BYTE:
                begin
                    // Header fields, picked out by byte position.
                    if (pos_reg == POS_VER_IHL)
                    begin
                        pkey_next = ckey_reg;
                        ihb_next  = {b[3:0], 2'b00};
                    end
                    else if (pos_reg == POS_LEN_HI)
                    begin
                        tlen_next = {b, 8'd0};
                    end
                    else if (pos_reg == POS_LEN_LO)
                    begin
                        tlen_next = {tlen_reg[15:8], b};
                    end
                    else if (pos_reg == POS_PROTO)
                    begin
                        proto_next = b;
                        if (hdr_ok && b == PROTO_UDP)
                        begin
                            pstart_next = pstart_udp;
                            armed_next  = 1'b1;
                        end
                    end
                    else if (hdr_ok && proto_reg == PROTO_TCP && pos_reg == tcp_doff_pos)
                    begin
                        if (doff >= MIN_DOFF)
                        begin
                            pstart_next = pstart_tcp;
                            armed_next  = 1'b1;
                        end
                    end

                    // Payload window, judged on the updated header fields.
                    change = armed_next && (pos_reg >= {9'd0, pstart_next})
                             && (pos_reg < tlen_next);
                    trunc  = stage.item.last_byte
                             && ((pos_reg < POS_LEN_LO)
                                 || (({1'b0, pos_reg} + 17'd1) < {1'b0, tlen_next}));

                    res_next.out_byte    = change ? (b ^ pkey_reg) : b;
                    res_next.out_last    = stage.item.last_byte;
                    res_next.was_changed = change;
                    res_next.truncated   = trunc;
                    res_valid_next       = 1'b1;

                    // End of packet clears the per-packet state.
                    if (stage.item.last_byte)
                    begin
                        pos_next    = 16'd0;
                        ihb_next    = 6'd0;
                        proto_next  = 8'd0;
                        tlen_next   = 16'd0;
                        pstart_next = 7'd0;
                        armed_next  = 1'b0;
                    end
                    else if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 16'd1;
                    end
                end
                default:
                begin
                    // Unused kind: dropped without effect.
                end
            endcase
        end
    end

    // Control and key state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 16'd0;
            ihb_reg       <= 6'd0;
            proto_reg     <= 8'd0;
            tlen_reg      <= 16'd0;
            pstart_reg    <= 7'd0;
            armed_reg     <= 1'b0;
            pkey_reg      <= KEY_RESET;
            ckey_reg      <= KEY_RESET;
            tick_reg      <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ihb_reg       <= ihb_next;
            proto_reg     <= proto_next;
            tlen_reg      <= tlen_next;
            pstart_reg    <= pstart_next;
            armed_reg     <= armed_next;
            pkey_reg      <= pkey_next;
            ckey_reg      <= ckey_next;
            tick_reg      <= tick_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== src/ipv4_payload_xor_scrambler.sv =====
// Top level of the IPv4 payload XOR scrambler: configuration register,
// input register and processing stage. Depends on ipsc_pkg, ipsc_in_reg, ipsc_core.

// The scrambler takes one beat per clock cycle while the result side keeps
// taking: a packet byte, a tick or a new key. Each packet byte yields one
// result beat, held first in the input register and then in the result
// register; ticks and key loads yield none. The header parser and key update
// between those two registers are combinational, so a beat can enter every
// cycle while the result side keeps taking. UDP and TCP payload bytes are
// XORed with the key latched on the packet's first byte, up to the total
// length. The rotate interval register (reset 10) should be written only
// while the block is idle.
module ipv4_payload_xor_scrambler
    import ipsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  item_t         item,
    output logic          result_valid,
    input  logic          result_ready,
    output result_t       result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);

    logic [15:0] interval_reg;
    stage_t      stage;
    logic        stage_take;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            interval_reg <= cfg_data;
        end
    end

    ipsc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .stage      (stage),
        .take       (stage_take)
    );

    ipsc_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage           (stage),
        .take            (stage_take),
        .rotate_interval (interval_reg),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result)
    );

`ifndef SYNTHESIS
    // A truncation flag only ever appears on the final byte of a packet.
    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.truncated || result.out_last))
        else $error("truncated set on a beat that is not the last");

    // A fresh result beat comes only from a packet byte taken the cycle before.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stage_take && stage.item.func == FUNC_BYTE))
        else $error("result beat without a packet byte behind it");

    // An empty input register always accepts a beat.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage.valid |-> item_ready)
        else $error("input register empty but not ready");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the IPv4 payload XOR scrambler: random IPv4 packets, ticks
// and key loads are checked against a cycle-free predictor. Depends on ipsc_pkg and the RTL.
module tb_top;
    import ipsc_pkg::*;

    // The one item kind the block drops without a result.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Shapes of packet that the generator can build.
    typedef enum int {
        PK_UDP,
        PK_TCP,
        PK_OTHER,
        PK_SHORT_IHL,
        PK_SHORT_DOFF,
        PK_CUT,
        PK_NO_HEADER,
        PK_EMPTY,
        PK_LONG
    } pkt_kind_e;
    localparam int NUM_RANDOM_KINDS = 8;

    // Ready patterns of the result side.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOST,
        RX_COIN
    } rx_mode_e;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item_beat = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result_beat;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    [15:0] cfg_data = '0;

    // Stimulus and checking bookkeeping.
    item_t   pending_items[$];
    result_t expected_bytes[$];
    logic    item_accepted = 1'b0;
    int      queued_count = 0;
    int      results_seen = 0;
    int      fail_count = 0;

    // Predicted state of the scrambler.
    logic [15:0] rot_interval = INTERVAL_RESET;
    logic [15:0] pos_count = '0;
    logic [5:0]  hdr_len = '0;
    logic [7:0]  proto_id = '0;
    logic [15:0] ip_total_len = '0;
    logic [6:0]  pl_start = '0;
    logic        pl_armed = 1'b0;
    logic [7:0]  latched_key = KEY_RESET;
    logic [7:0]  running_key = KEY_RESET;
    logic [15:0] tick_seen = '0;

    // Sender and receiver pacing.
    int       burst_left = 0;
    int       gap_left = 0;
    int       hold_left = 0;
    bit       long_hold_done = 1'b0;
    int       mode_left = 0;
    logic [1:0] rx_phase = '0;
    rx_mode_e rx_mode = RX_ALWAYS;

    ipv4_payload_xor_scrambler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_beat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Works out the result beat, if any, that one accepted item causes.
    task automatic predict_scramble(input item_t it);
        result_t want;
        int      p;
        int      doff_i;
        case (it.func)
            FUNC_TICK:
            begin
                tick_seen = tick_seen + 16'd1;
                if (tick_seen >= rot_interval)
                begin
                    running_key = running_key + KEY_STEP;
                    tick_seen = '0;
                end
            end
            FUNC_KEY:
            begin
                running_key = it.data_byte;
            end
            FUNC_BYTE:
            begin
                p = int'(pos_count);
                // Header fields are picked up as their bytes go past.
                if (p == POS_VER_IHL)
                begin
                    latched_key = running_key;
                    hdr_len = {it.data_byte[3:0], 2'b00};
                end
                else if (p == POS_LEN_HI)
                begin
                    ip_total_len = {it.data_byte, 8'h00};
                end
                else if (p == POS_LEN_LO)
                begin
                    ip_total_len[7:0] = it.data_byte;
                end
                else if (p == POS_PROTO)
                begin
                    proto_id = it.data_byte;
                    if (hdr_len >= MIN_HDR_BYTES && it.data_byte == PROTO_UDP)
                    begin
                        pl_start = {1'b0, hdr_len} + UDP_HDR_BYTES;
                        pl_armed = 1'b1;
                    end
                end
                else if (hdr_len >= MIN_HDR_BYTES && proto_id == PROTO_TCP &&
                         p == hdr_len + TCP_DOFF_OFS)
                begin
                    doff_i = int'(it.data_byte[7:4]);
                    if (doff_i >= MIN_DOFF)
                    begin
                        pl_start = 7'(hdr_len + 4 * doff_i);
                        pl_armed = 1'b1;
                    end
                end

                want.out_byte = it.data_byte;
                want.out_last = it.last_byte;
                want.was_changed = 1'b0;
                want.truncated = 1'b0;
                if (pl_armed && p >= pl_start && p < ip_total_len)
                begin
                    want.out_byte = it.data_byte ^ latched_key;
                    want.was_changed = 1'b1;
                end

                // The last byte closes the packet; otherwise the position moves on.
                if (it.last_byte)
                begin
                    want.truncated = (p < POS_LEN_LO) || (p + 1 < ip_total_len);
                    pos_count = '0;
                    hdr_len = '0;
                    proto_id = '0;
                    ip_total_len = '0;
                    pl_start = '0;
                    pl_armed = 1'b0;
                end
                else if (pos_count < POS_MAX)
                begin
                    pos_count = pos_count + 16'd1;
                end
                expected_bytes.push_back(want);
            end
            default:
            begin
            end
        endcase
    endtask

    // Compares one result beat with the oldest expected one.
    task automatic check_result(input result_t got);
        result_t want;
        if (expected_bytes.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result with nothing expected: ", $time,
                         "byte %02h last %0b changed %0b trunc %0b",
                         got.out_byte, got.out_last, got.was_changed, got.truncated);
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                got.was_changed !== want.was_changed || got.truncated !== want.truncated)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result mismatch: ", $time,
                             "expected byte %02h last %0b changed %0b trunc %0b, ",
                             want.out_byte, want.out_last, want.was_changed,
                             want.truncated,
                             "got byte %02h last %0b changed %0b trunc %0b",
                             got.out_byte, got.out_last, got.was_changed,
                             got.truncated);
            end
        end
    endtask

    // Prediction on accepted input beats and register writes, checking on result beats.
    always @(posedge clk)
    begin
        item_accepted <= item_valid && item_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                rot_interval = cfg_data;
            if (item_valid && item_ready)
                predict_scramble(item_beat);
            if (result_valid && result_ready)
            begin
                results_seen++;
                check_result(result_beat);
            end
        end
    end

    // Sender: pops pending beats in bursts, with gaps in between.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item_valid <= 1'b1;
                item_beat <= pending_items.pop_front();
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                              : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off once traffic is flowing, otherwise a changing pattern.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 40)
        begin
            long_hold_done = 1'b1;
            hold_left = 300;
            result_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(32, 256);
            end
            else
            begin
                mode_left--;
            end
            rx_phase = rx_phase + 2'd1;
            case (rx_mode)
                RX_ALWAYS: result_ready <= 1'b1;
                RX_MOST:   result_ready <= (rx_phase != 2'd3);
                default:   result_ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    task automatic push_item(input logic [1:0] f, input logic [7:0] d, input logic l);
        item_t it;
        it.func = f;
        it.data_byte = d;
        it.last_byte = l;
        pending_items.push_back(it);
        if (f != FUNC_UNUSED)
            queued_count++;
    endtask

    // A tick, a key load or an unused kind, with random payload bits.
    task automatic queue_side_item();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            push_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (r < 9)
            push_item(FUNC_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
            push_item(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Builds one packet of the given shape, bytes random outside the parsed fields.
    task automatic queue_packet(input pkt_kind_e kind);
        int          ihl;
        int          hdr;
        int          doff;
        int          start;
        int          tot;
        int          nbytes;
        int          i;
        logic [7:0]  proto_b;
        logic [7:0]  b;
        logic [15:0] len_field;
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        doff = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 15) : 5;
        proto_b = ($urandom_range(0, 1) == 1) ? PROTO_TCP : PROTO_UDP;
        case (kind)
            PK_UDP, PK_EMPTY, PK_LONG:
            begin
                proto_b = PROTO_UDP;
            end
            PK_TCP, PK_SHORT_DOFF:
            begin
                proto_b = PROTO_TCP;
            end
            PK_OTHER:
            begin
                proto_b = 8'($urandom_range(0, 255));
                if (proto_b == PROTO_TCP || proto_b == PROTO_UDP)
                    proto_b = proto_b + 8'd1;
            end
            PK_SHORT_IHL:
            begin
                ihl = $urandom_range(0, 4);
            end
            default:
            begin
            end
        endcase
        if (kind == PK_SHORT_DOFF)
            doff = $urandom_range(0, 4);
        if (kind == PK_LONG)
            ihl = 5;
        hdr = ihl * 4;
        start = (proto_b == PROTO_TCP) ? hdr + doff * 4 : hdr + 8;
        tot = start + $urandom_range(0, 12);
        nbytes = tot;

        // Length and byte count decide the payload window and truncation.
        case (kind)
            PK_EMPTY:
            begin
                tot = start - $urandom_range(0, 10);
                nbytes = start + 2;
            end
            PK_CUT:
            begin
                nbytes = $urandom_range(4, start + 8);
                tot = $urandom_range(nbytes + 1, 65535);
            end
            PK_NO_HEADER:
            begin
                nbytes = $urandom_range(1, (proto_b == PROTO_TCP) ? hdr + 12 : 9);
                tot = $urandom_range(0, 65535);
            end
            PK_LONG:
            begin
                tot = 65535;
                nbytes = 65538;
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    nbytes = tot + $urandom_range(1, 4);
            end
        endcase
        len_field = tot[15:0];

        for (i = 0; i < nbytes; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (i == POS_VER_IHL)
                b[3:0] = ihl[3:0];
            else if (i == POS_LEN_HI)
                b = len_field[15:8];
            else if (i == POS_LEN_LO)
                b = len_field[7:0];
            else if (i == POS_PROTO)
                b = proto_b;
            else if (proto_b == PROTO_TCP && hdr >= MIN_HDR_BYTES && i == hdr + TCP_DOFF_OFS)
                b[7:4] = doff[3:0];
            push_item(FUNC_BYTE, b, i == nbytes - 1);
            // Now and then a tick, a key load or an unused kind lands in the middle of the packet.
            if (i != nbytes - 1 && kind != PK_LONG && $urandom_range(0, 15) == 0)
                queue_side_item();
        end
    endtask

    // Mostly well-formed packets, with tick runs and stray items between them.
    task automatic queue_random_traffic(input int n_items);
        int base;
        int r;
        int k;
        base = queued_count;
        while (queued_count - base < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                repeat ($urandom_range(1, 25))
                    push_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
            else if (r < 15)
            begin
                queue_side_item();
            end
            else
            begin
                k = $urandom_range(0, 99);
                if (k < 35)
                    queue_packet(PK_UDP);
                else if (k < 65)
                    queue_packet(PK_TCP);
                else if (k < 72)
                    queue_packet(PK_OTHER);
                else if (k < 78)
                    queue_packet(PK_SHORT_IHL);
                else if (k < 84)
                    queue_packet(PK_SHORT_DOFF);
                else if (k < 90)
                    queue_packet(PK_CUT);
                else if (k < 95)
                    queue_packet(PK_NO_HEADER);
                else
                    queue_packet(PK_EMPTY);
            end
        end
    endtask

    // Waits until every beat is sent and answered, then lets the pipeline settle.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_interval(input logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence: directed beats, then random traffic under several intervals.
    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A key load of all ones, an unused kind and a tick, all with last set.
        push_item(FUNC_KEY, 8'hFF, 1'b1);
        push_item(FUNC_UNUSED, 8'hFF, 1'b1);
        push_item(FUNC_TICK, 8'h00, 1'b1);
        // One-byte packet: truncated.
        push_item(FUNC_BYTE, 8'hFF, 1'b1);
        push_item(FUNC_KEY, 8'h00, 1'b0);
        // Three bytes ending before the length field is complete.
        push_item(FUNC_BYTE, 8'h00, 1'b0);
        push_item(FUNC_BYTE, 8'hFF, 1'b0);
        push_item(FUNC_BYTE, 8'hFF, 1'b1);
        // Four bytes whose length field says four: not truncated, nothing scrambled.
        push_item(FUNC_BYTE, 8'h45, 1'b0);
        push_item(FUNC_BYTE, 8'h00, 1'b0);
        push_item(FUNC_BYTE, 8'h00, 1'b0);
        push_item(FUNC_BYTE, 8'h04, 1'b1);
        push_item(FUNC_KEY, KEY_RESET, 1'b0);

        // Every packet shape but PK_LONG once, then random traffic at the reset interval.
        for (k = 0; k < NUM_RANDOM_KINDS; k++)
            queue_packet(pkt_kind_e'(k));
        queue_random_traffic(20);
        wait_idle();

        write_interval(16'd1);
        queue_random_traffic(20);
        wait_idle();

        write_interval(16'd0);
        queue_random_traffic(20);
        wait_idle();

        write_interval(16'hFFFF);
        queue_random_traffic(20);
        wait_idle();

        write_interval(16'($urandom_range(2, 40)));
        queue_random_traffic(20);
        wait_idle();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
